>>> hw/rtl/cfv_pkg.sv
// cfv_pkg: shared types, constants and helpers of the command frame validator
// no dependencies; imported by every module of the block
package cfv_pkg;

  localparam int MaxLength    = 255;
  localparam int CommandChars = 4;
  localparam int TableEntries = 4;
  localparam int PosW         = $clog2(MaxLength + 2);
  localparam int CntW         = 3;
  localparam int CfgIdxW      = 3;
  localparam int WordW        = 8 * CommandChars;

  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MISSING   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_NO_STAR   = 3'd3,
    ST_BAD_CHARS = 3'd4,
    ST_NO_COLON  = 3'd5,
    ST_BAD_TERM  = 3'd6,
    ST_UNKNOWN   = 3'd7
  } cfv_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COUNT = 3'd0,
    REG_WORD0 = 3'd1,
    REG_WORD1 = 3'd2,
    REG_WORD2 = 3'd3,
    REG_WORD3 = 3'd4
  } cfv_reg_e;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_MARKER = 1'b1
  } cfv_kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       end_of_message;
  } cfv_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [WordW-1:0] command_code;
  } cfv_out_t;

  typedef struct packed {
    logic [CntW-1:0]                    count;
    logic [TableEntries-1:0][WordW-1:0] words;
  } cfv_cfg_t;

  typedef struct packed {
    logic     valid;
    cfv_out_t item;
  } cfv_res_t;

  function automatic logic is_upper(input logic [7:0] ch);
    return (ch >= CharUpA) && (ch <= CharUpZ);
  endfunction

endpackage

>>> hw/rtl/cfv_frame_check.sv
// cfv_frame_check: per-message state and the status decision for one item
// depends on cfv_pkg
module cfv_frame_check
  import cfv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  cfv_in_t  item_i,
  input  cfv_cfg_t cfg_i,
  output cfv_res_t res_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [WordW-1:0] cmd_q, cmd_d;
  logic start_bad_q, start_bad_d;
  logic letters_bad_q, letters_bad_d;
  logic colon_bad_q, colon_bad_d;
  logic prev_hash_q, prev_hash_d;

  logic            term_ok;
  logic            known;
  logic [CntW-1:0] n_cmd;
  cfv_status_e     status;

  // table lookup against the first n configured words
  always_comb begin
    n_cmd = (cfg_i.count > CntW'(TableEntries)) ? CntW'(TableEntries) : cfg_i.count;
    known = (n_cmd == '0);
    for (int i = 0; i < TableEntries; i++) begin
      if ((CntW'(i) < n_cmd) && (cfg_i.words[i] == cmd_d)) begin
        known = 1'b1;
      end
    end
  end

  always_comb begin
    pos_d         = pos_q;
    cmd_d         = cmd_q;
    start_bad_d   = start_bad_q;
    letters_bad_d = letters_bad_q;
    colon_bad_d   = colon_bad_q;
    prev_hash_d   = prev_hash_q;
    term_ok       = 1'b0;
    status        = ST_OK;
    res_o         = '0;

    if (item_i.kind == KIND_MARKER) begin
      status                  = ST_MISSING;
      res_o.valid             = 1'b1;
      res_o.item.status       = status;
      res_o.item.command_code = '0;
    end else begin
      if (pos_q == '0) begin
        start_bad_d = (item_i.data_byte != CharStar);
      end
      for (int k = 1; k <= CommandChars; k++) begin
        if (pos_q == PosW'(k)) begin
          if (!is_upper(item_i.data_byte)) begin
            letters_bad_d = 1'b1;
          end
          cmd_d[8*(CommandChars-k) +: 8] = cmd_q[8*(CommandChars-k) +: 8] | item_i.data_byte;
        end
      end
      if (pos_q == PosW'(CommandChars + 1)) begin
        colon_bad_d = (item_i.data_byte != CharColon);
      end
      term_ok     = (item_i.data_byte == CharHash) && prev_hash_q;
      prev_hash_d = (item_i.data_byte == CharHash);
      if (pos_q <= PosW'(MaxLength)) begin
        pos_d = pos_q + PosW'(1);
      end

      if (pos_d > PosW'(MaxLength)) begin
        status = ST_TOO_LONG;
      end else if (start_bad_d) begin
        status = ST_NO_STAR;
      end else if (letters_bad_d || (pos_d < PosW'(CommandChars + 1))) begin
        status = ST_BAD_CHARS;
      end else if (colon_bad_d || (pos_d < PosW'(CommandChars + 2))) begin
        status = ST_NO_COLON;
      end else if (!term_ok) begin
        status = ST_BAD_TERM;
      end else if (!known) begin
        status = ST_UNKNOWN;
      end else begin
        status = ST_OK;
      end

      res_o.valid             = item_i.end_of_message;
      res_o.item.status       = status;
      res_o.item.command_code = cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      cmd_q         <= '0;
      start_bad_q   <= 1'b0;
      letters_bad_q <= 1'b0;
      colon_bad_q   <= 1'b0;
      prev_hash_q   <= 1'b0;
    end else if (step_i) begin
      if (res_o.valid) begin
        // every result closes the message
        pos_q         <= '0;
        cmd_q         <= '0;
        start_bad_q   <= 1'b0;
        letters_bad_q <= 1'b0;
        colon_bad_q   <= 1'b0;
        prev_hash_q   <= 1'b0;
      end else begin
        pos_q         <= pos_d;
        cmd_q         <= cmd_d;
        start_bad_q   <= start_bad_d;
        letters_bad_q <= letters_bad_d;
        colon_bad_q   <= colon_bad_d;
        prev_hash_q   <= prev_hash_d;
      end
    end
  end

endmodule

>>> hw/rtl/command_frame_validator.sv
// command_frame_validator: top level, input register, config registers, result register
// depends on cfv_pkg and cfv_frame_check
//
// Checks command frames of the form '*CCCC:...##' sent one byte per item, each
// item flagged with end_of_message on the final byte; a marker item (kind = 1)
// stands for an absent message, drops any partial message and yields status
// missing. Exactly one result item leaves for each marker and for each final
// byte, carrying the status (too long, no star, bad command chars, no colon,
// bad terminator, unknown command, in that priority) and bytes one to four
// packed with the first in the top byte. Items flow at one per cycle while no
// result is held back by out_stall_i: an item is taken into the input register,
// its checks and the four parallel table compares run combinationally on that
// register, and the result is registered in the output register. The input
// side stalls only while a result is held in the output register by out_stall_i
// and the input register is occupied. Configuration writes are always ready and
// must be issued only while the block holds no message.
module command_frame_validator
  import cfv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfv_in_t             in_item_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cfv_out_t            out_item_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [WordW-1:0]    cfg_data_i
);

  // input register
  logic    in_valid_q;
  cfv_in_t in_item_q;
  // result register
  logic     out_valid_q;
  cfv_out_t out_item_q;
  // configuration
  cfv_cfg_t cfg_q;

  logic     in_accept;
  logic     stage_adv;
  cfv_res_t res;

  // the stage moves on unless the output register is full and held
  assign stage_adv  = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (stage_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

  // per-message checks
  cfv_frame_check u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (stage_adv),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // output register, refilled in the same cycle it is emptied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_adv && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && res.valid) begin
      out_item_q <= res.item;
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COUNT: cfg_q.count    <= cfg_data_i[CntW-1:0];
        REG_WORD0: cfg_q.words[0] <= cfg_data_i;
        REG_WORD1: cfg_q.words[1] <= cfg_data_i;
        REG_WORD2: cfg_q.words[2] <= cfg_data_i;
        REG_WORD3: cfg_q.words[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/cfv_checker.sv
// cfv_checker: port-level assertions for the command frame validator
// depends on cfv_pkg; bound to command_frame_validator below
module cfv_checker
  import cfv_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input cfv_out_t out_item_o
);

  // a missing message carries no command
  a_missing_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_MISSING) |-> (out_item_o.command_code == '0))
    else $error("missing status with non-zero command code");

  // past the letter check all four command bytes are uppercase letters
  a_letters_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.status == ST_OK) || (out_item_o.status == ST_NO_COLON) ||
                    (out_item_o.status == ST_BAD_TERM) || (out_item_o.status == ST_UNKNOWN))
    |-> (is_upper(out_item_o.command_code[31:24]) && is_upper(out_item_o.command_code[23:16]) &&
         is_upper(out_item_o.command_code[15:8]) && is_upper(out_item_o.command_code[7:0])))
    else $error("status past letter check with non-letter command byte");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

endmodule

bind command_frame_validator cfv_checker u_cfv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
